@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the date conversion block.
// Depends on nothing; each macro takes a label, clock, reset and the two terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/esd_pkg.sv @@
// Types, constants and calendar functions for the epoch seconds to date block.
// Depends on nothing; used by esd_sub_unit and epoch_seconds_to_date_unit.
package esd_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t diff;
    logic  ge;
  } sub_res_t;

  localparam int unsigned SECONDS_PER_DAY = 24 * 60 * 60;

  // 86400 = 675 * 2^7: drop seven low bits, then multiply by the reciprocal of 675.
  localparam int DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD = SECONDS_PER_DAY >> DAY_SHIFT;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W = 26;
  localparam int SHIFTED_W = WORD_W - DAY_SHIFT;
  localparam int PROD_W = SHIFTED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DAY_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4   = 2'(1970 % 4);
  localparam logic [6:0]  EPOCH_MOD100 = 7'(1970 % 100);
  localparam logic [8:0]  EPOCH_MOD400 = 9'(1970 % 400);

  localparam logic [8:0] YEAR_DAYS = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ src/esd_sub_unit.sv @@
// Shared 32-bit subtract and compare unit of the date conversion sequencer.
// Depends on esd_pkg for the word and result types.
module esd_sub_unit (
  input  esd_pkg::word_t    a,
  input  esd_pkg::word_t    b,
  output esd_pkg::sub_res_t res
);

  logic [esd_pkg::WORD_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[esd_pkg::WORD_W-1:0];
  assign res.ge = ~wide[esd_pkg::WORD_W];

endmodule

@@ src/epoch_seconds_to_date_unit.sv @@
// Converts unsigned Unix seconds to a Gregorian year, month and day.
// A transaction is taken when start is high and busy is low. The result appears
// on year_out, month_out and day_out for exactly one cycle with done high, and
// must be captured then: the receiver cannot stall it. A transaction first gets
// whole days by a reciprocal multiply, then takes off the days of each elapsed
// year, then the days of each whole month, and then raises done; the next
// transaction can be taken while done is high. The year and month steps share
// the one 32-bit subtract and compare unit, and busy stays high for the whole
// conversion.
// Depends on esd_pkg, esd_sub_unit and assert_macros.svh.
`include "assert_macros.svh"

module epoch_seconds_to_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] seconds,
  output logic        busy,
  output logic        done,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_YEAR  = 4'b0100,
    ST_MONTH = 4'b1000
  } state_t;

  state_t state;

  esd_pkg::word_t          acc;
  logic [11:0]             year;
  logic [3:0]              month;
  logic [1:0]              mod4;
  logic [6:0]              mod100;
  logic [8:0]              mod400;

  logic                    leap;
  logic [esd_pkg::PROD_W-1:0] day_prod;
  esd_pkg::word_t          sub_a;
  esd_pkg::word_t          sub_b;
  esd_pkg::sub_res_t       sub_res;

  assign leap = (mod400 == 9'd0) || ((mod4 == 2'd0) && (mod100 != 7'd0));
  assign day_prod = {{esd_pkg::RECIP_W{1'b0}}, acc[esd_pkg::WORD_W-1:esd_pkg::DAY_SHIFT]}
                  * {{esd_pkg::SHIFTED_W{1'b0}}, esd_pkg::DAY_RECIP};

  always_comb begin
    sub_a = acc;
    sub_b = esd_pkg::word_t'(esd_pkg::month_len(month, leap));
    unique case (state)
      ST_YEAR: begin
        sub_b = esd_pkg::word_t'(leap ? esd_pkg::LEAP_YEAR_DAYS : esd_pkg::YEAR_DAYS);
      end
      ST_MONTH, ST_IDLE, ST_DIV: begin
      end
      default: begin
      end
    endcase
  end

  esd_sub_unit u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            acc    <= seconds;
            year   <= esd_pkg::EPOCH_YEAR;
            month  <= esd_pkg::MONTH_JAN;
            mod4   <= esd_pkg::EPOCH_MOD4;
            mod100 <= esd_pkg::EPOCH_MOD100;
            mod400 <= esd_pkg::EPOCH_MOD400;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          // keep the whole-day quotient, drop the time of day
          acc   <= esd_pkg::word_t'(day_prod[esd_pkg::PROD_W-1:esd_pkg::RECIP_SHIFT]);
          state <= ST_YEAR;
        end
        ST_YEAR: begin
          if (sub_res.ge) begin
            acc    <= sub_res.diff;
            year   <= year + 12'd1;
            mod4   <= mod4 + 2'd1;
            mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
            mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
          end else begin
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (sub_res.ge && (month != esd_pkg::MONTH_DEC)) begin
            acc   <= sub_res.diff;
            month <= month + 4'd1;
          end else begin
            year_out  <= year;
            month_out <= month;
            day_out   <= acc[4:0] + 5'd1;
            done      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `ASSERT_SAME(a_month_range, clk, rst, done, (month_out >= 4'd1) && (month_out <= 4'd12))

endmodule

@@ tb/sv/tb_epoch_seconds_to_date_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_date_unit: drives second counts,
// predicts the calendar date of each and checks every done strobe against it.
// Depends on the RTL of epoch_seconds_to_date_unit (and through it on esd_pkg).

class date_board;
  localparam int unsigned DAY_SECONDS = 86400;
  localparam int unsigned FIRST_YEAR  = 1970;

  typedef struct {
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  date_t       expected_dates[$];
  int unsigned mismatches = 0;

  static function bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  static function int unsigned days_in_month(int unsigned m, bit leap);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return (m == 2 && leap) ? 29 : lens[m-1];
  endfunction

  // Second count of midnight that starts the given date.
  static function longint midnight_of(int unsigned y, int unsigned m, int unsigned d);
    longint days;
    days = d - 1;
    for (int unsigned yy = FIRST_YEAR; yy < y; yy++) days += is_leap(yy) ? 366 : 365;
    for (int unsigned mm = 1; mm < m; mm++) days += days_in_month(mm, is_leap(y));
    return days * DAY_SECONDS;
  endfunction

  static function date_t civil_date(logic [31:0] secs);
    date_t       d;
    int unsigned days;
    int unsigned y;
    int unsigned m;
    days = secs / DAY_SECONDS;
    y = FIRST_YEAR;
    while (days >= (is_leap(y) ? 366 : 365)) begin
      days -= is_leap(y) ? 366 : 365;
      y++;
    end
    m = 1;
    while (m < 12 && days >= days_in_month(m, is_leap(y))) begin
      days -= days_in_month(m, is_leap(y));
      m++;
    end
    d.seconds = secs;
    d.year    = 12'(y);
    d.month   = 4'(m);
    d.day     = 5'(days + 1);
    return d;
  endfunction

  function void note_seconds(logic [31:0] secs);
    expected_dates.push_back(civil_date(secs));
  endfunction

  function void check_date(logic [11:0] year, logic [3:0] month, logic [4:0] day);
    date_t want;
    if (expected_dates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: result %0d-%0d-%0d with no transaction outstanding",
                 year, month, day);
      return;
    end
    want = expected_dates.pop_front();
    if (year !== want.year || month !== want.month || day !== want.day) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: seconds=%0d expected %0d-%0d-%0d got %0d-%0d-%0d",
                 want.seconds, want.year, want.month, want.day, year, month, day);
    end
  endfunction

  function int unsigned pending();
    return expected_dates.size();
  endfunction
endclass

module tb_epoch_seconds_to_date_unit;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 630;
  localparam int SETTLE_CYCLES = 200;
  localparam int unsigned DAY_SECONDS = 86400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] seconds = '0;
  logic        busy;
  logic        done;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;

  date_board   board = new();
  int unsigned idle_cycles = 0;

  always #5 clk = ~clk;

  epoch_seconds_to_date_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .seconds   (seconds),
    .busy      (busy),
    .done      (done),
    .year_out  (year_out),
    .month_out (month_out),
    .day_out   (day_out)
  );

  // Record accepted transactions, check results, and watch for a hang.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) board.note_seconds(seconds);
      if (done) board.check_date(year_out, month_out, day_out);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("** epoch_seconds_to_date_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold until no conversion is outstanding and the last strobe has passed.
  task automatic wait_drained();
    do @(posedge clk); while (board.pending() != 0 || done);
  endtask

  task automatic send_seconds(input logic [31:0] value, input int unsigned gap,
                              input bit drain);
    if (gap != 0 || drain) begin
      start   <= 1'b0;
      seconds <= $urandom;
      if (drain) wait_drained();
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    seconds <= value;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] near_boundary();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned last;
    longint      s;
    y    = $urandom_range(1970, 2105);
    m    = $urandom_range(1, 12);
    last = board.days_in_month(m, board.is_leap(y));
    case ($urandom_range(0, 2))
      0:       d = 1;
      1:       d = last;
      default: d = $urandom_range(1, last);
    endcase
    s = board.midnight_of(y, m, d);
    case ($urandom_range(0, 2))
      0:       s = s - 1;
      1:       s = s + DAY_SECONDS - 1;
      default: s = s + $urandom_range(0, DAY_SECONDS - 1);
    endcase
    if (s < 0) s = 0;
    return s[31:0];
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [31:0] value;
    bit          calm;
    bit          drain;

    directed = '{
      32'd0, 32'd86399, 32'd86400,
      32'(board.midnight_of(1971, 1, 1) - 1),
      32'(board.midnight_of(1971, 1, 1)),
      32'(board.midnight_of(1972, 2, 28)),
      32'(board.midnight_of(1972, 2, 29)),
      32'(board.midnight_of(1972, 3, 1)),
      32'(board.midnight_of(1972, 12, 31)),
      32'(board.midnight_of(1973, 1, 1)),
      32'(board.midnight_of(2000, 2, 29)),
      32'(board.midnight_of(2001, 1, 1) - 1),
      32'h7FFF_FFFF, 32'h8000_0000,
      32'(board.midnight_of(2100, 3, 1) - 1),
      32'(board.midnight_of(2100, 3, 1)),
      32'(board.midnight_of(2106, 1, 1)),
      32'(board.midnight_of(2106, 2, 7)),
      32'hFFFF_FFFE, 32'hFFFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_seconds(directed[i], $urandom_range(0, 12), i == 0 || $urandom_range(0, 3) == 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every third stretch of 70 transactions runs back to back, but for a drain at every 97th.
      calm = ((i / 70) % 3) == 1;
      case ($urandom_range(0, 3))
        0, 1:    value = $urandom;
        2:       value = near_boundary();
        default: value = $urandom_range(0, 800 * DAY_SECONDS);
      endcase
      drain = (i % 97 == 0) || (!calm && $urandom_range(0, 3) == 0);
      send_seconds(value, calm ? 0 : $urandom_range(0, 12), drain);
    end

    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** epoch_seconds_to_date_unit: PASSED **");
    end else begin
      $display("** epoch_seconds_to_date_unit: FAILED **");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/esd_pkg.sv
src/esd_sub_unit.sv
src/epoch_seconds_to_date_unit.sv
tb/sv/tb_epoch_seconds_to_date_unit.sv
